[design/cfc_pkg.sv]
package cfc_pkg;

    localparam int DEF_MAX_FEET = 4;

    localparam int VEL_W      = 16;
    localparam int STANCE_W   = 3;
    localparam int MASS_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int WEIGHT_W   = 24;
    localparam int RATIO_W    = 16;
    localparam int LIM_W      = 24;
    localparam int OUT_W      = 24;

    localparam int MW_W       = 32;  // mass * |yaw|
    localparam int K_W        = 47;  // mass * |yaw| * scale
    localparam int PROD_W     = 62;  // k * |vel|
    localparam int FRC_W      = 33;  // per-foot magnitude before the clamp
    localparam int AB_W       = 31;  // normalized magnitude
    localparam int SQ_W       = 63;  // a^2 + b^2
    localparam int ROOT_W     = 32;
    localparam int NUM_W      = 56;  // a * limit + m / 2
    localparam int QUO_W      = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BODY_MASS   = 3'd0,
        REG_BODY_WEIGHT = 3'd1,
        REG_FORCE_SCALE = 3'd2,
        REG_MAX_FORCE   = 3'd3,
        REG_MAX_RATIO   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [FRC_W-1:0] fx;
        logic [FRC_W-1:0] fy;
        logic             sx;
        logic             sy;
    } force_t;

endpackage

[design/cfc_front.sv]
module cfc_front #(
    parameter int MAX_FEET = cfc_pkg::DEF_MAX_FEET
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cfc_pkg::VEL_W-1:0]     vel_x,
    input  logic [cfc_pkg::VEL_W-1:0]     vel_y,
    input  logic [cfc_pkg::VEL_W-1:0]     yaw_rate,
    input  logic [cfc_pkg::STANCE_W-1:0]  stance_feet,
    input  logic [cfc_pkg::MASS_W-1:0]    body_mass,
    input  logic [cfc_pkg::SCALE_W-1:0]   force_scale,
    output logic                          out_valid,
    output cfc_pkg::force_t               out_force
);
    import cfc_pkg::*;

    localparam int FEET_W   = $clog2(MAX_FEET + 1);
    localparam int DIV_STG  = 4;
    localparam int DIV_STEP = 9;
    localparam int DIVD_W   = DIV_STG * DIV_STEP;

    typedef struct packed {
        logic [DIVD_W-1:0] n;
        logic [FEET_W-1:0] r;
        logic [DIVD_W-1:0] q;
    } lane_t;

    function automatic logic [VEL_W-1:0] mag16(logic [VEL_W-1:0] x);
        return x[VEL_W-1] ? VEL_W'(-x) : x;
    endfunction

    function automatic lane_t div_chunk(lane_t l, logic [FEET_W-1:0] f);
        lane_t         o;
        logic [FEET_W:0] r2;
        logic          ge;
        o = l;
        for (int j = 0; j < DIV_STEP; j++) begin
            r2  = {o.r, o.n[DIVD_W-1]};
            ge  = (r2 >= {1'b0, f});
            o.r = ge ? FEET_W'(r2 - {1'b0, f}) : r2[FEET_W-1:0];
            o.n = {o.n[DIVD_W-2:0], 1'b0};
            o.q = {o.q[DIVD_W-2:0], ge};
        end
        return o;
    endfunction

    // stage 1: magnitudes, feet, mass * |yaw|
    logic              f1_v_reg;
    logic [VEL_W-1:0]  f1_vxm_reg, f1_vym_reg;
    logic [MW_W-1:0]   f1_mw_reg;
    logic [FEET_W-1:0] f1_feet_reg;
    logic              f1_sx_reg, f1_sy_reg;

    logic [VEL_W-1:0]  wm;
    logic [MW_W-1:0]   f1_mw_next;
    logic [FEET_W-1:0] f1_feet_next;
    logic [3:0]        st4;

    always_comb begin
        wm  = mag16(yaw_rate);
        st4 = {1'b0, stance_feet};
        // no feet: zero force, divide by one
        priority if (st4 == 4'd0) begin
            f1_feet_next = FEET_W'(1);
            f1_mw_next   = '0;
        end else if (st4 > 4'(MAX_FEET)) begin
            f1_feet_next = FEET_W'(MAX_FEET);
            f1_mw_next   = body_mass * wm;
        end else begin
            f1_feet_next = FEET_W'(stance_feet);
            f1_mw_next   = body_mass * wm;
        end
    end

    // stage 2
    logic              f2_v_reg;
    logic [VEL_W-1:0]  f2_vxm_reg, f2_vym_reg;
    logic [K_W-1:0]    f2_k_reg;
    logic [FEET_W-1:0] f2_feet_reg;
    logic              f2_sx_reg, f2_sy_reg;
    logic [MW_W+SCALE_W-1:0] kfull;

    assign kfull = f1_mw_reg * force_scale;

    // stage 3
    logic              f3_v_reg;
    logic [PROD_W-1:0] f3_px_reg, f3_py_reg;
    logic [FEET_W-1:0] f3_feet_reg;
    logic              f3_sx_reg, f3_sy_reg;
    logic [K_W+VEL_W-1:0] pxf, pyf;

    assign pxf = f2_k_reg * f2_vym_reg;
    assign pyf = f2_k_reg * f2_vxm_reg;

    // stage 4: round, drop 30 fraction bits
    logic              f4_v_reg;
    logic [FRC_W-1:0]  f4_tx_reg, f4_ty_reg;
    logic [FEET_W-1:0] f4_feet_reg;
    logic              f4_sx_reg, f4_sy_reg;
    logic [PROD_W:0]   sumx, sumy, half;

    always_comb begin
        half = (PROD_W + 1)'(f3_feet_reg) << 29;
        sumx = {1'b0, f3_px_reg} + half;
        sumy = {1'b0, f3_py_reg} + half;
    end

    // divide by the foot count, nine quotient bits a stage
    logic              dv_v_reg    [DIV_STG];
    lane_t             dx_reg      [DIV_STG];
    lane_t             dy_reg      [DIV_STG];
    logic [FEET_W-1:0] dfeet_reg   [DIV_STG];
    logic              dsx_reg     [DIV_STG];
    logic              dsy_reg     [DIV_STG];
    lane_t             dx_next     [DIV_STG];
    lane_t             dy_next     [DIV_STG];
    lane_t             ent_x, ent_y;

    always_comb begin
        ent_x.n = DIVD_W'(f4_tx_reg);
        ent_x.r = '0;
        ent_x.q = '0;
        ent_y.n = DIVD_W'(f4_ty_reg);
        ent_y.r = '0;
        ent_y.q = '0;
        dx_next[0] = div_chunk(ent_x, f4_feet_reg);
        dy_next[0] = div_chunk(ent_y, f4_feet_reg);
        for (int s = 1; s < DIV_STG; s++) begin
            dx_next[s] = div_chunk(dx_reg[s-1], dfeet_reg[s-1]);
            dy_next[s] = div_chunk(dy_reg[s-1], dfeet_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
            for (int s = 0; s < DIV_STG; s++) dv_v_reg[s] <= 1'b0;
        end else if (en) begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
            dv_v_reg[0] <= f4_v_reg;
            for (int s = 1; s < DIV_STG; s++) dv_v_reg[s] <= dv_v_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_vxm_reg  <= mag16(vel_x);
            f1_vym_reg  <= mag16(vel_y);
            f1_mw_reg   <= f1_mw_next;
            f1_feet_reg <= f1_feet_next;
            f1_sx_reg   <= (yaw_rate[VEL_W-1] == vel_y[VEL_W-1]);
            f1_sy_reg   <= (yaw_rate[VEL_W-1] != vel_x[VEL_W-1]);

            f2_vxm_reg  <= f1_vxm_reg;
            f2_vym_reg  <= f1_vym_reg;
            f2_k_reg    <= kfull[K_W-1:0];
            f2_feet_reg <= f1_feet_reg;
            f2_sx_reg   <= f1_sx_reg;
            f2_sy_reg   <= f1_sy_reg;

            f3_px_reg   <= pxf[PROD_W-1:0];
            f3_py_reg   <= pyf[PROD_W-1:0];
            f3_feet_reg <= f2_feet_reg;
            f3_sx_reg   <= f2_sx_reg;
            f3_sy_reg   <= f2_sy_reg;

            f4_tx_reg   <= sumx[PROD_W:30];
            f4_ty_reg   <= sumy[PROD_W:30];
            f4_feet_reg <= f3_feet_reg;
            f4_sx_reg   <= f3_sx_reg;
            f4_sy_reg   <= f3_sy_reg;

            dfeet_reg[0] <= f4_feet_reg;
            dsx_reg[0]   <= f4_sx_reg;
            dsy_reg[0]   <= f4_sy_reg;
            for (int s = 1; s < DIV_STG; s++) begin
                dfeet_reg[s] <= dfeet_reg[s-1];
                dsx_reg[s]   <= dsx_reg[s-1];
                dsy_reg[s]   <= dsy_reg[s-1];
            end
            for (int s = 0; s < DIV_STG; s++) begin
                dx_reg[s] <= dx_next[s];
                dy_reg[s] <= dy_next[s];
            end
        end
    end

    assign out_valid    = dv_v_reg[DIV_STG-1];
    assign out_force.fx = dx_reg[DIV_STG-1].q[FRC_W-1:0];
    assign out_force.fy = dy_reg[DIV_STG-1].q[FRC_W-1:0];
    assign out_force.sx = dsx_reg[DIV_STG-1];
    assign out_force.sy = dsy_reg[DIV_STG-1];

endmodule

[design/cfc_isqrt.sv]
module cfc_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [cfc_pkg::SQ_W-1:0]    in_val,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [cfc_pkg::ROOT_W-1:0]  out_root,
    output logic [SIDE_W-1:0]           out_side
);
    import cfc_pkg::*;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } sq_t;

    function automatic sq_t sq_step(sq_t x, logic [SQ_W-1:0] bitv);
        sq_t         o;
        logic [SQ_W:0] t;
        t = {1'b0, x.res} + {1'b0, bitv};
        if ({1'b0, x.v} >= t) begin
            o.v   = x.v - t[SQ_W-1:0];
            o.res = (x.res >> 1) + bitv;
        end else begin
            o.v   = x.v;
            o.res = x.res >> 1;
        end
        return o;
    endfunction

    logic              v_reg    [ROOT_W];
    sq_t               st_reg   [ROOT_W];
    sq_t               st_next  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    sq_t               ent;

    // one result bit a stage, top bit first
    always_comb begin
        ent.v      = in_val;
        ent.res    = '0;
        st_next[0] = sq_step(ent, SQ_W'(1) << (2 * (ROOT_W - 1)));
        for (int j = 1; j < ROOT_W; j++) begin
            st_next[j] = sq_step(st_reg[j-1], SQ_W'(1) << (2 * (ROOT_W - 1 - j)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < ROOT_W; j++) v_reg[j] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int j = 1; j < ROOT_W; j++) v_reg[j] <= v_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int j = 1; j < ROOT_W; j++) side_reg[j] <= side_reg[j-1];
            for (int j = 0; j < ROOT_W; j++) st_reg[j] <= st_next[j];
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = st_reg[ROOT_W-1].res[ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];

`ifndef SYNTHESIS
    // remainder of a floor square root never exceeds twice the root
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ({1'b0, st_reg[ROOT_W-1].v} <= {st_reg[ROOT_W-1].res, 1'b0}))
        else $error("isqrt remainder out of range");
`endif

endmodule

[design/cfc_div.sv]
module cfc_div #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [cfc_pkg::NUM_W-1:0]   num_x,
    input  logic [cfc_pkg::NUM_W-1:0]   num_y,
    input  logic [cfc_pkg::ROOT_W-1:0]  den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [cfc_pkg::QUO_W-1:0]   quo_x,
    output logic [cfc_pkg::QUO_W-1:0]   quo_y,
    output logic [SIDE_W-1:0]           out_side
);
    import cfc_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0] r;
        logic [QUO_W-1:0]  lo;
        logic [QUO_W-1:0]  q;
    } lane_t;

    function automatic lane_t div_step(lane_t l, logic [ROOT_W-1:0] d);
        lane_t         o;
        logic [ROOT_W:0] r2;
        logic          ge;
        r2   = {l.r, l.lo[QUO_W-1]};
        ge   = (r2 >= {1'b0, d});
        o.r  = ge ? ROOT_W'(r2 - {1'b0, d}) : r2[ROOT_W-1:0];
        o.lo = {l.lo[QUO_W-2:0], 1'b0};
        o.q  = {l.q[QUO_W-2:0], ge};
        return o;
    endfunction

    logic              v_reg    [QUO_W];
    lane_t             x_reg    [QUO_W];
    lane_t             y_reg    [QUO_W];
    lane_t             x_next   [QUO_W];
    lane_t             y_next   [QUO_W];
    logic [ROOT_W-1:0] d_reg    [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    lane_t             ent_x, ent_y;

    // numerator stays below den * 2^QUO_W, so the top word starts below den
    always_comb begin
        ent_x.r  = num_x[NUM_W-1:QUO_W];
        ent_x.lo = num_x[QUO_W-1:0];
        ent_x.q  = '0;
        ent_y.r  = num_y[NUM_W-1:QUO_W];
        ent_y.lo = num_y[QUO_W-1:0];
        ent_y.q  = '0;
        x_next[0] = div_step(ent_x, den);
        y_next[0] = div_step(ent_y, den);
        for (int j = 1; j < QUO_W; j++) begin
            x_next[j] = div_step(x_reg[j-1], d_reg[j-1]);
            y_next[j] = div_step(y_reg[j-1], d_reg[j-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < QUO_W; j++) v_reg[j] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int j = 1; j < QUO_W; j++) v_reg[j] <= v_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0]    <= den;
            side_reg[0] <= in_side;
            for (int j = 1; j < QUO_W; j++) begin
                d_reg[j]    <= d_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
            for (int j = 0; j < QUO_W; j++) begin
                x_reg[j] <= x_next[j];
                y_reg[j] <= y_next[j];
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign quo_x     = x_reg[QUO_W-1].q;
    assign quo_y     = y_reg[QUO_W-1].q;
    assign out_side  = side_reg[QUO_W-1];

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && d_reg[QUO_W-1] != '0) |->
            (x_reg[QUO_W-1].r < d_reg[QUO_W-1] && y_reg[QUO_W-1].r < d_reg[QUO_W-1]))
        else $error("divider remainder not below divisor");
`endif

endmodule

[design/centripetal_force_clamp.sv]
// Per-foot centripetal force with magnitude clamp. Each beat on the s_ side
// carries a velocity command, a yaw rate and the stance foot count; one beat
// leaves on the m_ side for each, in order. A new beat is taken every cycle
// while the m_ side does not stall. The pipeline is the 32-stage square root
// and the 24-stage divider that rescale a clamped vector, plus 13 stages of
// multiply, foot-count divide and compare. A stall on the m_ side holds the
// whole pipeline, and s_tready follows it. The user must write registers
// through cfg_wr_en / cfg_index / cfg_wdata only while the block is idle; the
// block itself does not enforce this. Indexes past the last register are ignored.
module centripetal_force_clamp #(
    parameter int MAX_FEET = cfc_pkg::DEF_MAX_FEET
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vel_x[15:0], vel_y[31:16], yaw_rate[47:32], stance_feet[50:48], zero pad
    input  logic [cfc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // force_x[23:0], force_y[47:24]
    output logic [cfc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import cfc_pkg::*;

    localparam int AL_W = AB_W + LIM_W;
    localparam logic [FRC_W-1:0] POS_MAX = FRC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [FRC_W-1:0] NEG_MAX = FRC_W'(1 << (OUT_W - 1));

    typedef struct packed {
        logic [AL_W-1:0] al;
        logic [AL_W-1:0] bl;
        force_t          f;
        logic            over;
    } sq_side_t;

    typedef struct packed {
        force_t f;
        logic   over;
        logic   mnz;
    } dv_side_t;

    function automatic logic [OUT_W-1:0] pack_out(logic [FRC_W-1:0] mag, logic neg);
        logic [FRC_W-1:0] lim;
        if (neg && mag != '0) begin
            lim = (mag > NEG_MAX) ? NEG_MAX : mag;
            return OUT_W'(-lim);
        end
        lim = (mag > POS_MAX) ? POS_MAX : mag;
        return lim[OUT_W-1:0];
    endfunction

    // configuration
    logic [MASS_W-1:0]   body_mass_reg;
    logic [WEIGHT_W-1:0] body_weight_reg;
    logic [SCALE_W-1:0]  force_scale_reg;
    logic [LIM_W-1:0]    max_force_reg;
    logic [RATIO_W-1:0]  max_ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_mass_reg   <= '0;
            body_weight_reg <= '0;
            force_scale_reg <= SCALE_W'(4096);
            max_force_reg   <= '0;
            max_ratio_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BODY_MASS:   body_mass_reg   <= cfg_wdata[MASS_W-1:0];
                REG_BODY_WEIGHT: body_weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                REG_FORCE_SCALE: force_scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_MAX_FORCE:   max_force_reg   <= cfg_wdata[LIM_W-1:0];
                REG_MAX_RATIO:   max_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // limit follows the registers; items reach it long after a write
    logic [RATIO_W+WEIGHT_W-1:0] rsum;
    logic [LIM_W-1:0]            limit_reg, limit_next;
    logic [2*LIM_W-1:0]          lsq_reg;

    always_comb begin
        rsum = max_ratio_reg * body_weight_reg + (RATIO_W + WEIGHT_W)'(32768);
        limit_next = (max_force_reg != '0) ? max_force_reg
                                           : rsum[RATIO_W+WEIGHT_W-1:RATIO_W];
    end

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
        lsq_reg   <= limit_reg * limit_reg;
    end

    // handshake: the output register stalls everything behind it
    logic en;
    logic out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    logic   fr_v;
    force_t fr_f;

    cfc_front #(
        .MAX_FEET(MAX_FEET)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .vel_x       (s_tdata[15:0]),
        .vel_y       (s_tdata[31:16]),
        .yaw_rate    (s_tdata[47:32]),
        .stance_feet (s_tdata[50:48]),
        .body_mass   (body_mass_reg),
        .force_scale (force_scale_reg),
        .out_valid   (fr_v),
        .out_force   (fr_f)
    );

    // M1: squares for the limit test, normalize below 2^31
    logic               m1_v_reg, m1_big_reg;
    force_t             m1_f_reg;
    logic [2*LIM_W-1:0] m1_fxsq_reg, m1_fysq_reg;
    logic [AB_W-1:0]    m1_a_reg, m1_b_reg;
    logic [FRC_W-1:0]   or_ab, sh_a, sh_b;

    always_comb begin
        or_ab = fr_f.fx | fr_f.fy;
        priority if (or_ab[FRC_W-1]) begin
            sh_a = fr_f.fx >> 2;
            sh_b = fr_f.fy >> 2;
        end else if (or_ab[FRC_W-2]) begin
            sh_a = fr_f.fx >> 1;
            sh_b = fr_f.fy >> 1;
        end else begin
            sh_a = fr_f.fx;
            sh_b = fr_f.fy;
        end
    end

    // M2: over test, squares of the normalized pair
    logic               m2_v_reg, m2_over_reg;
    force_t             m2_f_reg;
    logic [AB_W-1:0]    m2_a_reg, m2_b_reg;
    logic [2*AB_W-1:0]  m2_a2_reg, m2_b2_reg;
    logic [2*LIM_W:0]   sum_sq;

    assign sum_sq = {1'b0, m1_fxsq_reg} + {1'b0, m1_fysq_reg};

    // M3: sum of squares, scaled numerators
    logic               m3_v_reg;
    logic [SQ_W-1:0]    m3_s_reg;
    sq_side_t           m3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end else if (en) begin
            m1_v_reg <= fr_v;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_f_reg    <= fr_f;
            m1_big_reg  <= (fr_f.fx[FRC_W-1:LIM_W] != '0) || (fr_f.fy[FRC_W-1:LIM_W] != '0);
            m1_fxsq_reg <= fr_f.fx[LIM_W-1:0] * fr_f.fx[LIM_W-1:0];
            m1_fysq_reg <= fr_f.fy[LIM_W-1:0] * fr_f.fy[LIM_W-1:0];
            m1_a_reg    <= sh_a[AB_W-1:0];
            m1_b_reg    <= sh_b[AB_W-1:0];

            m2_f_reg    <= m1_f_reg;
            m2_over_reg <= (limit_reg != '0) &&
                           (m1_big_reg || sum_sq > {1'b0, lsq_reg});
            m2_a_reg    <= m1_a_reg;
            m2_b_reg    <= m1_b_reg;
            m2_a2_reg   <= m1_a_reg * m1_a_reg;
            m2_b2_reg   <= m1_b_reg * m1_b_reg;

            m3_s_reg         <= {1'b0, m2_a2_reg} + {1'b0, m2_b2_reg};
            m3_side_reg.al   <= m2_a_reg * limit_reg;
            m3_side_reg.bl   <= m2_b_reg * limit_reg;
            m3_side_reg.f    <= m2_f_reg;
            m3_side_reg.over <= m2_over_reg;
        end
    end

    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    cfc_isqrt #(
        .SIDE_W($bits(sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_v_reg),
        .in_val    (m3_s_reg),
        .in_side   (m3_side_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // D0: add half the root for rounding
    logic              d0_v_reg;
    logic [NUM_W-1:0]  d0_numx_reg, d0_numy_reg;
    logic [ROOT_W-1:0] d0_m_reg;
    dv_side_t          d0_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_v_reg <= 1'b0;
        end else if (en) begin
            d0_v_reg <= sq_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_numx_reg      <= NUM_W'(sq_side.al) + NUM_W'(sq_root >> 1);
            d0_numy_reg      <= NUM_W'(sq_side.bl) + NUM_W'(sq_root >> 1);
            d0_m_reg         <= sq_root;
            d0_side_reg.f    <= sq_side.f;
            d0_side_reg.over <= sq_side.over;
            d0_side_reg.mnz  <= (sq_root != '0);
        end
    end

    logic             dv_v;
    logic [QUO_W-1:0] quo_x, quo_y;
    dv_side_t         dv_side;

    cfc_div #(
        .SIDE_W($bits(dv_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d0_v_reg),
        .num_x     (d0_numx_reg),
        .num_y     (d0_numy_reg),
        .den       (d0_m_reg),
        .in_side   (d0_side_reg),
        .out_valid (dv_v),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_side  (dv_side)
    );

    // pick clamped or raw magnitude, saturate, sign
    logic [FRC_W-1:0] sel_x, sel_y;
    logic             use_q;

    always_comb begin
        use_q = dv_side.over && dv_side.mnz;
        sel_x = use_q ? FRC_W'(quo_x) : dv_side.f.fx;
        sel_y = use_q ? FRC_W'(quo_y) : dv_side.f.fy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {pack_out(sel_y, dv_side.f.sy), pack_out(sel_x, dv_side.f.sx)};
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a rescaled component never exceeds the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v && use_q) |-> (FRC_W'(quo_x) <= FRC_W'(limit_reg) &&
                             FRC_W'(quo_y) <= FRC_W'(limit_reg)))
        else $error("clamped force above limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v && dv_side.over) |-> (limit_reg != '0))
        else $error("clamp taken with zero limit");
`endif

endmodule
